/* sv/pqnce_pkg.sv */
`timescale 1ns / 1ps

package pqnce_pkg;

  localparam int unsigned SUBVEC_COUNT = 4;
  localparam int unsigned CODEWORDS    = 256;
  localparam int unsigned SUBVEC_LEN   = 16;

  localparam int unsigned BOOK_W    = (SUBVEC_COUNT > 1) ? $clog2(SUBVEC_COUNT) : 1;
  localparam int unsigned WORD_W    = $clog2(CODEWORDS);
  localparam int unsigned DIM_W     = (SUBVEC_LEN > 1) ? $clog2(SUBVEC_LEN) : 1;
  localparam int unsigned ADDR_W    = BOOK_W + WORD_W;
  localparam int unsigned RAM_DEPTH = 1 << ADDR_W;

  localparam int unsigned SQ_W   = 16;
  localparam int unsigned GROUPS = (SUBVEC_LEN + 3) / 4;
  localparam int unsigned GRP_W  = SQ_W + 2;
  localparam int unsigned SUM_W  = SQ_W + DIM_W + 1;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] ZP_RESET = 8'd128;

  typedef logic signed [7:0] elem_t;
  typedef elem_t [SUBVEC_LEN-1:0] qvec_t;

  typedef struct packed {
    logic [BOOK_W-1:0] book;
    qvec_t             qvec;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DIM_W-1:0]  dim;
    elem_t             data;
  } cbwr_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

/* sv/pq_nearest_codeword_encoder_unit.sv */
`timescale 1ns / 1ps

// channel   signals                                        transaction at
// input     start_i, busy_o, req_type_i .. entry_dim_i     start_i & !busy_o
// config    cfg_valid_i, cfg_ready_o, cfg_data_i           cfg_valid_i & cfg_ready_o
// result    done_o, code_index_o, subvector_number_o,      done_o (one cycle)
//           position_last_o
//
// latent bytes are taken one per cycle into the query buffer while busy_o is
// low; a full subvector goes to a two-entry job queue; busy_o is high while
// that queue is full or a codebook write waits.
// one search reads one codeword per cycle (16 lanes) from the codebook ram;
// the back end takes the next job from the queue only once the last codeword
// of the search has drained through its pipeline, and the result is
// registered onto done_o as that last codeword is compared.
// a codebook write is held until the queue and the search are empty, then
// written. reset clears control only; the codebook is not cleared.
// results cannot be stalled and appear exactly once on done_o.
module pq_nearest_codeword_encoder_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              req_type_i,
  input  logic [7:0]        latent_byte_i,
  input  logic signed [7:0] entry_value_i,
  input  logic [1:0]        entry_book_i,
  input  logic [7:0]        entry_word_i,
  input  logic [3:0]        entry_dim_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_data_i,
  output logic              done_o,
  output logic [7:0]        code_index_o,
  output logic [1:0]        subvector_number_o,
  output logic              position_last_o
);

  import pqnce_pkg::*;

  qstat_t            qstat;
  job_t              push_job, head_job;
  cbwr_t             cbwr;
  logic              push, pop;
  logic              back_idle;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  qvec_t             cb_rd;

  pqnce_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .req_type_i    (req_type_i),
    .latent_byte_i (latent_byte_i),
    .entry_value_i (entry_value_i),
    .entry_book_i  (entry_book_i),
    .entry_word_i  (entry_word_i),
    .entry_dim_i   (entry_dim_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .qstat_i       (qstat),
    .back_idle_i   (back_idle),
    .push_o        (push),
    .job_o         (push_job),
    .cbwr_o        (cbwr)
  );

  pqnce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .qstat_o (qstat)
  );

  for (genvar i = 0; i < SUBVEC_LEN; i++) begin : g_lane
    pqnce_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (cbwr.en && (cbwr.dim == DIM_W'(i))),
      .waddr_i (cbwr.addr),
      .wdata_i (cbwr.data),
      .re_i    (rd_en),
      .raddr_i (rd_addr),
      .rdata_o (cb_rd[i])
    );
  end

  pqnce_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .qstat_i            (qstat),
    .job_i              (head_job),
    .pop_o              (pop),
    .rd_en_o            (rd_en),
    .rd_addr_o          (rd_addr),
    .cb_i               (cb_rd),
    .idle_o             (back_idle),
    .done_o             (done_o),
    .code_index_o       (code_index_o),
    .subvector_number_o (subvector_number_o),
    .position_last_o    (position_last_o)
  );

endmodule

/* sv/pqnce_ram.sv */
`timescale 1ns / 1ps

module pqnce_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/pqnce_front.sv */
`timescale 1ns / 1ps

module pqnce_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               req_type_i,
  input  logic [7:0]         latent_byte_i,
  input  logic signed [7:0]  entry_value_i,
  input  logic [1:0]         entry_book_i,
  input  logic [7:0]         entry_word_i,
  input  logic [3:0]         entry_dim_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i,
  input  pqnce_pkg::qstat_t  qstat_i,
  input  logic               back_idle_i,
  output logic               push_o,
  output pqnce_pkg::job_t    job_o,
  output pqnce_pkg::cbwr_t   cbwr_o
);

  import pqnce_pkg::*;

  logic              accept;
  logic              latent_acc;
  logic              in_range;
  logic              wr_go;
  logic              sub_done;
  elem_t             byte_adj;
  logic              wr_pend_q, wr_pend_d;
  logic [7:0]        zp_q, zp_d;
  logic [DIM_W-1:0]  dim_q, dim_d;
  logic [BOOK_W-1:0] book_q, book_d;
  logic [ADDR_W-1:0] wr_addr_q;
  logic [DIM_W-1:0]  wr_dim_q;
  elem_t             wr_data_q;
  qvec_t             qbuf_q, qbuf_d;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = wr_pend_q | qstat_i.full;
  assign accept      = start_i & ~busy_o;
  assign latent_acc  = accept & ~req_type_i;
  assign wr_go       = wr_pend_q & qstat_i.empty & back_idle_i;
  assign byte_adj    = elem_t'(latent_byte_i - zp_q);
  assign sub_done    = dim_q == DIM_W'(SUBVEC_LEN - 1);

  assign in_range = (32'(entry_book_i) < SUBVEC_COUNT) &&
                    (32'(entry_word_i) < CODEWORDS) &&
                    (32'(entry_dim_i) < SUBVEC_LEN);

  always_comb begin
    zp_d      = zp_q;
    wr_pend_d = wr_pend_q;
    dim_d     = dim_q;
    book_d    = book_q;
    qbuf_d    = qbuf_q;
    if (cfg_valid_i && cfg_ready_o) begin
      zp_d = cfg_data_i;
    end
    if (accept && req_type_i && in_range) begin
      wr_pend_d = 1'b1;
    end else if (wr_go) begin
      wr_pend_d = 1'b0;
    end
    if (latent_acc) begin
      qbuf_d[dim_q] = byte_adj;
      if (sub_done) begin
        dim_d  = '0;
        book_d = (book_q == BOOK_W'(SUBVEC_COUNT - 1)) ? '0 : book_q + 1'b1;
      end else begin
        dim_d = dim_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zp_q      <= ZP_RESET;
      wr_pend_q <= 1'b0;
      dim_q     <= '0;
      book_q    <= '0;
    end else begin
      zp_q      <= zp_d;
      wr_pend_q <= wr_pend_d;
      dim_q     <= dim_d;
      book_q    <= book_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qbuf_q <= qbuf_d;
    if (accept && req_type_i) begin
      wr_addr_q <= {BOOK_W'(entry_book_i), WORD_W'(entry_word_i)};
      wr_dim_q  <= DIM_W'(entry_dim_i);
      wr_data_q <= entry_value_i;
    end
  end

  assign push_o     = latent_acc & sub_done;
  assign job_o.book = book_q;
  assign job_o.qvec = qbuf_d;

  assign cbwr_o.en   = wr_go;
  assign cbwr_o.addr = wr_addr_q;
  assign cbwr_o.dim  = wr_dim_q;
  assign cbwr_o.data = wr_data_q;

endmodule

/* sv/pqnce_queue.sv */
`timescale 1ns / 1ps

module pqnce_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pqnce_pkg::job_t   job_i,
  input  logic              pop_i,
  output pqnce_pkg::job_t   job_o,
  output pqnce_pkg::qstat_t qstat_o
);

  import pqnce_pkg::*;

  job_t              ent_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= job_i;
    end
  end

  assign job_o         = ent_q[rptr_q];
  assign qstat_o.empty = cnt_q == '0;
  assign qstat_o.full  = cnt_q == QCNT_W'(QDEPTH);

endmodule

/* sv/pqnce_back.sv */
`timescale 1ns / 1ps

module pqnce_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pqnce_pkg::qstat_t         qstat_i,
  input  pqnce_pkg::job_t           job_i,
  output logic                      pop_o,
  output logic                      rd_en_o,
  output logic [pqnce_pkg::ADDR_W-1:0] rd_addr_o,
  input  pqnce_pkg::qvec_t          cb_i,
  output logic                      idle_o,
  output logic                      done_o,
  output logic [7:0]                code_index_o,
  output logic [1:0]                subvector_number_o,
  output logic                      position_last_o
);

  import pqnce_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_DRAIN = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [WORD_W-1:0] k_q, k_d;
  job_t              job_q;

  logic              rd_v_q, sq_v_q, gs_v_q, tot_v_q;
  logic [WORD_W-1:0] rd_idx_q, sq_idx_q, gs_idx_q, tot_idx_q;
  logic [SQ_W-1:0]   sq_q [SUBVEC_LEN];
  logic [SQ_W-1:0]   sq_d [SUBVEC_LEN];
  logic [GRP_W-1:0]  gs_q [GROUPS];
  logic [GRP_W-1:0]  gs_d [GROUPS];
  logic [SUM_W-1:0]  tot_q, tot_d;
  logic [SUM_W-1:0]  best_q;
  logic [WORD_W-1:0] bestk_q;
  logic              better;
  logic              last_cw;

  logic              done_q;
  logic [7:0]        code_q;
  logic [1:0]        sub_q;
  logic              plast_q;

  assign idle_o    = state_q == S_IDLE;
  assign pop_o     = (state_q == S_IDLE) && !qstat_i.empty;
  assign rd_en_o   = state_q == S_ISSUE;
  assign rd_addr_o = {job_q.book, k_q};
  assign last_cw   = tot_v_q && (tot_idx_q == WORD_W'(CODEWORDS - 1));
  assign better    = (tot_idx_q == '0) || (tot_q < best_q);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (!qstat_i.empty) begin
          state_d = S_ISSUE;
          k_d     = '0;
        end
      end
      S_ISSUE: begin
        if (k_q == WORD_W'(CODEWORDS - 1)) begin
          state_d = S_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (last_cw) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // squared differences, one lane per dimension
  always_comb begin
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    for (int i = 0; i < SUBVEC_LEN; i++) begin
      diff  = 9'(job_q.qvec[i]) - 9'(cb_i[i]);
      prod  = diff * diff;
      sq_d[i] = prod[SQ_W-1:0];
    end
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      gs_d[g] = '0;
      for (int j = 0; j < 4; j++) begin
        if (g * 4 + j < SUBVEC_LEN) begin
          gs_d[g] = gs_d[g] + GRP_W'(sq_q[g * 4 + j]);
        end
      end
    end
  end

  always_comb begin
    tot_d = '0;
    for (int g = 0; g < GROUPS; g++) begin
      tot_d = tot_d + SUM_W'(gs_q[g]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rd_v_q  <= 1'b0;
      sq_v_q  <= 1'b0;
      gs_v_q  <= 1'b0;
      tot_v_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= state_q == S_ISSUE;
      sq_v_q  <= rd_v_q;
      gs_v_q  <= sq_v_q;
      tot_v_q <= gs_v_q;
      done_q  <= last_cw;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    rd_idx_q  <= k_q;
    sq_idx_q  <= rd_idx_q;
    gs_idx_q  <= sq_idx_q;
    tot_idx_q <= gs_idx_q;
    sq_q      <= sq_d;
    gs_q      <= gs_d;
    tot_q     <= tot_d;
    if (pop_o) begin
      job_q <= job_i;
    end
    if (tot_v_q && better) begin
      best_q  <= tot_q;
      bestk_q <= tot_idx_q;
    end
    if (last_cw) begin
      code_q  <= better ? 8'(tot_idx_q) : 8'(bestk_q);
      sub_q   <= 2'(job_q.book);
      plast_q <= job_q.book == BOOK_W'(SUBVEC_COUNT - 1);
    end
  end

  assign done_o             = done_q;
  assign code_index_o       = code_q;
  assign subvector_number_o = sub_q;
  assign position_last_o    = plast_q;

endmodule
